// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros: assertion helpers shared by the RTL modules
// Clocked property checks on clk, with and without the reset guard.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, and skip it while reset is held.
`define BWA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge of clk, including the edges during reset.
`define BWA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/bwa_pkg.sv -----
// ----------------------------------------------------------------------------
// bwa_pkg: shared types and constants of the bounded wrapping accumulator
// Widths, configuration register indexes and the request and response of the
// remainder unit.
// ----------------------------------------------------------------------------
package bwa_pkg;

    // Width of a Q16.16 value: delta, sum, bounds
    localparam int DATA_W = 32;
    // Signed width of sum + delta - low_bound
    localparam int X_W    = DATA_W + 2;
    // Width of the magnitude of that offset
    localparam int MAG_W  = DATA_W + 1;
    // Width of the iteration counter of the remainder unit
    localparam int CNT_W  = $clog2(MAG_W);

    localparam int CFG_ADDR_W = 2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_LOW_BOUND  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_HIGH_BOUND = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] CFG_WRAP_EN    = CFG_ADDR_W'(2);

    localparam logic signed [DATA_W-1:0] SUM_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SUM_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Request to the remainder unit: offset magnitude, offset sign and range
    typedef struct packed {
        logic              start;
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic [DATA_W-1:0] divisor;
    } bwa_mod_req_t;

    // Response: non-negative remainder in [0, divisor)
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] rem;
    } bwa_mod_rsp_t;

endpackage

// ----- rtl/bwa_mod_unit.sv -----
// ----------------------------------------------------------------------------
// bwa_mod_unit: bit-serial remainder unit
// Restoring remainder of a signed offset by an unsigned range, one bit a
// cycle through a single shared subtractor; a final step maps a negative
// offset into [0, range).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bwa_mod_unit
    import bwa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  bwa_mod_req_t req,
    output bwa_mod_rsp_t rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ITER = 2'd1;
    localparam logic [1:0] ST_FIX  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic [DATA_W-1:0] div_reg, div_next;
    logic              neg_reg, neg_next;

    // Shared subtractor
    logic [DATA_W:0]   sub_a, sub_b;
    logic [DATA_W+1:0] sub_diff;
    logic [DATA_W:0]   shifted;

    assign shifted  = {rem_reg, mag_reg[MAG_W-1]};
    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};

    always_comb
    begin
        if (state_reg == ST_FIX)
        begin
            sub_a = {1'b0, div_reg};
            sub_b = {1'b0, rem_reg};
        end
        else
        begin
            sub_a = shifted;
            sub_b = {1'b0, div_reg};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        mag_next   = mag_reg;
        div_next   = div_reg;
        neg_next   = neg_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.start)
                begin
                    rem_next   = '0;
                    mag_next   = req.mag;
                    div_next   = req.divisor;
                    neg_next   = req.neg;
                    cnt_next   = CNT_W'(MAG_W - 1);
                    state_next = ST_ITER;
                end
            end
            ST_ITER:
            begin
                // keep the difference when it does not go negative
                if (!sub_diff[DATA_W+1])
                begin
                    rem_next = sub_diff[DATA_W-1:0];
                end
                else
                begin
                    rem_next = shifted[DATA_W-1:0];
                end
                mag_next = {mag_reg[MAG_W-2:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIX;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_FIX:
            begin
                // fold a negative offset into [0, range)
                if (neg_reg && (rem_reg != '0))
                begin
                    rem_next = sub_diff[DATA_W-1:0];
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        mag_reg <= mag_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

    `BWA_ASSERT(a_rem_below_range, done_reg |-> (rem_reg < div_reg), "remainder not below range")
    `BWA_ASSERT(a_done_after_fix, done_reg |-> ($past(state_reg) == ST_FIX), "done without final step")
    `BWA_ASSERT_ALWAYS(a_no_done_in_reset, !rst_n |-> !done_reg, "done during reset")

endmodule

// ----- rtl/bounded_wrapping_accumulator_core.sv -----
// ----------------------------------------------------------------------------
// bounded_wrapping_accumulator_core: running Q16.16 sum with bounds
// Adds a signed delta per item; restarts on a rising reset level; wraps into
// or clamps to [low_bound, high_bound] when the bounds are active.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one item: delta (signed Q16.16)
//   and reset_level. Output channel out_valid/out_ready returns one item per
//   input item: sum, the running sum after that item.
//   Configuration: cfg_we, cfg_addr, cfg_wdata write low_bound (index 0),
//   high_bound (index 1) and wrap_enable (index 2); write only while no item
//   is in flight. Other indexes are ignored.
//   Order: an item in clamp mode, without bounds, or with a rising reset
//   level goes from ST_IDLE to ST_DONE, which raises out_valid once the
//   output slot is free. In wrap mode ST_MOD comes between, where the
//   bit-serial remainder unit runs DATA_W + 1 = 33 iterations and a fold step.
//   Throughput: one item at a time; in_ready is high only while idle, so the
//   next item is taken only after the last one has loaded its result, in wrap
//   mode after the remainder unit's one-bit-per-cycle loop has finished.
//   The output register holds the result while the receiver stalls, and the
//   next item is accepted meanwhile; its result waits until the slot frees.
//   Reset clears the sum, the last reset level, all bounds and wrap_enable.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_wrapping_accumulator_core
    import bwa_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [DATA_W-1:0]        cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] delta,
    input  logic                     reset_level,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] sum
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MOD  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Configuration
    logic signed [DATA_W-1:0] low_bound_reg;
    logic signed [DATA_W-1:0] high_bound_reg;
    logic                     wrap_enable_reg;

    // Control
    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       last_level_reg, last_level_next;

    // Data
    logic signed [DATA_W-1:0] running_sum_reg, running_sum_next;
    logic signed [DATA_W-1:0] res_reg, res_next;

    // Item math
    logic                     in_accept;
    logic                     bounded;
    logic                     rise;
    logic                     use_mod;
    logic signed [DATA_W:0]   add_wide;
    logic signed [DATA_W-1:0] add_sat;
    logic signed [DATA_W-1:0] clamped;
    logic signed [DATA_W-1:0] direct_res;
    logic signed [X_W-1:0]    offset;
    logic signed [X_W-1:0]    offset_neg;
    logic        [DATA_W:0]   range_wide;
    logic                     load_out;

    bwa_mod_req_t mod_req;
    bwa_mod_rsp_t mod_rsp;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign sum       = running_sum_reg;

    // Configuration writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_bound_reg   <= '0;
            high_bound_reg  <= '0;
            wrap_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_LOW_BOUND:  low_bound_reg   <= cfg_wdata;
                CFG_HIGH_BOUND: high_bound_reg  <= cfg_wdata;
                CFG_WRAP_EN:    wrap_enable_reg <= cfg_wdata[0];
                default:        ;
            endcase
        end
    end

    assign bounded = high_bound_reg > low_bound_reg;
    assign rise    = reset_level && !last_level_reg;
    assign use_mod = !rise && bounded && wrap_enable_reg;

    // Saturating add at the sum limits
    assign add_wide = {running_sum_reg[DATA_W-1], running_sum_reg} + {delta[DATA_W-1], delta};

    always_comb
    begin
        if (add_wide[DATA_W] != add_wide[DATA_W-1])
        begin
            add_sat = add_wide[DATA_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            add_sat = add_wide[DATA_W-1:0];
        end
    end

    // Clamp into [low_bound, high_bound]
    always_comb
    begin
        if (add_sat < low_bound_reg)
        begin
            clamped = low_bound_reg;
        end
        else if (add_sat > high_bound_reg)
        begin
            clamped = high_bound_reg;
        end
        else
        begin
            clamped = add_sat;
        end
    end

    always_comb
    begin
        if (rise)
        begin
            direct_res = bounded ? low_bound_reg : '0;
        end
        else if (!bounded)
        begin
            direct_res = add_sat;
        end
        else
        begin
            direct_res = clamped;
        end
    end

    // Offset from the low bound, reduced modulo the range by the remainder unit
    assign offset = X_W'(running_sum_reg) + X_W'(delta) - X_W'(low_bound_reg);
    assign offset_neg = -offset;
    assign range_wide = {high_bound_reg[DATA_W-1], high_bound_reg}
                      - {low_bound_reg[DATA_W-1], low_bound_reg};

    assign mod_req.start   = in_accept && use_mod;
    assign mod_req.neg     = offset[X_W-1];
    assign mod_req.mag     = offset[X_W-1] ? offset_neg[MAG_W-1:0] : offset[MAG_W-1:0];
    assign mod_req.divisor = range_wide[DATA_W-1:0];

    bwa_mod_unit u_mod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next       = state_reg;
        res_next         = res_reg;
        last_level_next  = last_level_reg;
        running_sum_next = running_sum_reg;
        out_valid_next   = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    // the level after this item is its own level in every case
                    last_level_next = reset_level;
                    res_next        = direct_res;
                    state_next      = use_mod ? ST_MOD : ST_DONE;
                end
            end
            ST_MOD:
            begin
                if (mod_rsp.done)
                begin
                    res_next   = low_bound_reg + mod_rsp.rem;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the output slot frees
                if (load_out)
                begin
                    running_sum_next = res_reg;
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            last_level_reg  <= 1'b0;
            running_sum_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            last_level_reg  <= last_level_next;
            running_sum_reg <= running_sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    `BWA_ASSERT(a_one_in_flight, in_accept |=> (state_reg != ST_IDLE), "second item taken while busy")
    `BWA_ASSERT(a_mod_done_in_mod, mod_rsp.done |-> (state_reg == ST_MOD), "remainder done outside wrap step")
    `BWA_ASSERT(a_load_shows, load_out |=> (out_valid_reg && (state_reg == ST_IDLE)), "result not presented")

endmodule
